### src/polyline_arc_projection_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyline arc projection unit
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_ARC_PROJECTION_UNIT_MACROS_SVH
`define POLYLINE_ARC_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication
`define PAP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("polyline arc projection check failed");

// next-cycle implication
`define PAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("polyline arc projection check failed");

`endif

### src/pap_pkg.sv
// ----------------------------------------------------------------------------
// Polyline arc projection package
// Widths, constants and arithmetic helpers shared by the projection unit.
// ----------------------------------------------------------------------------
package pap_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MUL_W      = COORD_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LEN_W      = PROD_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int DIST_W     = 64;
    localparam int RATIO_FRAC = 32;
    localparam int QUOT_W     = RATIO_FRAC;
    localparam int N_MUL      = 4;
    localparam int MUL_CNT_W  = $clog2(MUL_W);
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic [MUL_W-1:0]          t_mag;
    typedef logic [PROD_W-1:0]         t_prod;
    typedef logic [LEN_W-1:0]          t_len;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [QUOT_W-1:0]         t_quot;

    localparam t_mag  RATIO_ONE  = MUL_W'(1) << RATIO_FRAC;
    localparam t_prod ROUND_HALF = PROD_W'(1) << (RATIO_FRAC - 1);
    localparam t_dist DIST_MAX   = '1;

    function automatic t_mag mag_of(input t_diff v);
        return v[DIFF_W-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    function automatic t_dot apply_sign(input t_prod p, input logic neg);
        t_dot v;
        v = t_dot'({1'b0, p});
        return neg ? -v : v;
    endfunction

    function automatic t_mag round_mag(input t_prod p);
        t_prod s;
        s = p + ROUND_HALF;
        return s[RATIO_FRAC+MUL_W-1:RATIO_FRAC];
    endfunction

    function automatic t_diff signed_mag(input t_mag m, input logic neg);
        t_diff v;
        v = t_diff'(m);
        return neg ? -v : v;
    endfunction

endpackage

### src/pap_vtx_if.sv
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying one polyline vertex and the query point.
// ----------------------------------------------------------------------------
interface pap_vtx_if;
    logic            valid;
    logic            ready;
    pap_pkg::t_coord query_x;
    pap_pkg::t_coord query_y;
    pap_pkg::t_coord vertex_x;
    pap_pkg::t_coord vertex_y;
    pap_pkg::t_coord vertex_arc;
    logic            first_vertex;
    logic            last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, vertex_arc,
               first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, vertex_arc,
               first_vertex, last_vertex,
        output ready
    );
endinterface

### src/pap_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one projection result per polyline pass.
// ----------------------------------------------------------------------------
interface pap_res_if;
    logic            valid;
    logic            ready;
    logic            found;
    pap_pkg::t_coord arc_position;

    modport source (output valid, found, arc_position, input ready);
    modport sink   (input valid, found, arc_position, output ready);
endinterface

### src/pap_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pap_serial_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  pap_pkg::t_mag         i_a,
    input  pap_pkg::t_mag         i_b,
    output logic                  o_done,
    output pap_pkg::t_prod        o_prod
);
    pap_pkg::t_mag                   r_a;
    pap_pkg::t_prod                  r_p;
    pap_pkg::t_prod                  n_p;
    logic [pap_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [pap_pkg::MUL_W:0]         w_sum;

    assign w_sum = {1'b0, r_p[pap_pkg::PROD_W-1:pap_pkg::MUL_W]} + {1'b0, r_a};

    always_comb begin
        if (r_p[0]) begin
            n_p = {w_sum, r_p[pap_pkg::MUL_W-1:1]};
        end else begin
            n_p = {1'b0, r_p[pap_pkg::PROD_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pap_pkg::MUL_CNT_W'(pap_pkg::MUL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{pap_pkg::MUL_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

### src/pap_serial_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring radix-2 divider giving a Q0.32 fraction of num / den (num < den).
// ----------------------------------------------------------------------------
module pap_serial_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pap_pkg::t_len  i_num,
    input  pap_pkg::t_len  i_den,
    output logic           o_done,
    output pap_pkg::t_quot o_quot
);
    pap_pkg::t_len                  r_rem;
    pap_pkg::t_len                  r_den;
    pap_pkg::t_quot                 r_q;
    logic [pap_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [pap_pkg::LEN_W:0]        w_rem2;
    logic [pap_pkg::LEN_W:0]        w_diff;
    logic                           w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, r_den};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pap_pkg::DIV_CNT_W'(pap_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[pap_pkg::LEN_W-1:0] : w_rem2[pap_pkg::LEN_W-1:0];
            r_q   <= {r_q[pap_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### src/polyline_arc_projection_unit.sv
// ----------------------------------------------------------------------------
// Polyline arc projection unit
// Projects a query point onto a streamed polyline and reports the arc length
// of the nearest projection once the last vertex has been taken.
//
//   channel   direction  transaction
//   i_vtx     in         query point, one vertex, first/last marks
//   o_res     out        found flag, arc position (one per pass)
//
// A vertex that closes a segment runs, before the next ready, four serial
// multiplies, one 32-step divide, and the bit-serial multipliers again for
// interpolation and distance. When the projection clamps to a segment end
// the divide is skipped. A vertex without a segment goes from setup straight
// to the finish state; a last vertex then passes through the emit state,
// which waits on o_res. Reset is synchronous; o_res is a holding register.
// ----------------------------------------------------------------------------
module polyline_arc_projection_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pap_vtx_if.sink   i_vtx,
    pap_res_if.source o_res
);
    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SETUP    = 12'b0000_0000_0010,
        S_PROD     = 12'b0000_0000_0100,
        S_RATIO    = 12'b0000_0000_1000,
        S_DIV      = 12'b0000_0001_0000,
        S_SCALE_GO = 12'b0000_0010_0000,
        S_SCALE    = 12'b0000_0100_0000,
        S_DIFF     = 12'b0000_1000_0000,
        S_SQ_GO    = 12'b0001_0000_0000,
        S_SQ       = 12'b0010_0000_0000,
        S_FIN      = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } t_state;

    localparam int MSB = pap_pkg::DIFF_W - 1;

    t_state          r_state;
    t_state          n_state;
    logic            r_have_prev;
    pap_pkg::t_coord r_prev_x;
    pap_pkg::t_coord r_prev_y;
    pap_pkg::t_coord r_prev_arc;
    logic            r_seg;
    logic            r_last;
    pap_pkg::t_diff  r_vx;
    pap_pkg::t_diff  r_vy;
    pap_pkg::t_diff  r_ex;
    pap_pkg::t_diff  r_ey;
    pap_pkg::t_diff  r_ds;
    pap_pkg::t_coord r_arc0;
    pap_pkg::t_len   r_len;
    pap_pkg::t_dot   r_dot;
    pap_pkg::t_mag   r_ratio;
    pap_pkg::t_mag   r_tx;
    pap_pkg::t_mag   r_ty;
    pap_pkg::t_mag   r_ts;
    pap_pkg::t_diff  r_dx;
    pap_pkg::t_diff  r_dy;
    pap_pkg::t_coord r_s;
    pap_pkg::t_dist  r_dist;
    pap_pkg::t_dist  r_best_dist;
    pap_pkg::t_coord r_best_arc;
    logic            r_have_best;
    logic            r_out_valid;
    logic            r_found;
    pap_pkg::t_coord r_out_arc;

    logic            w_accept;
    logic            w_emit;
    logic            w_better;
    pap_pkg::t_diff  w_vx;
    pap_pkg::t_diff  w_vy;
    pap_pkg::t_diff  w_ex;
    pap_pkg::t_diff  w_ey;
    pap_pkg::t_diff  w_ds;
    pap_pkg::t_diff  w_s_full;
    pap_pkg::t_len   w_len;
    pap_pkg::t_dot   w_dot;
    logic [pap_pkg::PROD_W:0] w_dsum;
    logic            w_ratio_zero;
    logic            w_ratio_one;
    logic            w_div_start;
    logic            w_div_done;
    pap_pkg::t_quot  w_quot;
    logic            w_mul_start;
    pap_pkg::t_mag   w_mul_a    [pap_pkg::N_MUL];
    pap_pkg::t_mag   w_mul_b    [pap_pkg::N_MUL];
    pap_pkg::t_prod  w_mul_prod [pap_pkg::N_MUL];
    logic            w_mul_done [pap_pkg::N_MUL];

    assign i_vtx.ready = (r_state == S_IDLE);
    assign w_accept    = i_vtx.valid & i_vtx.ready;
    assign w_emit      = (r_state == S_EMIT) & (~r_out_valid | o_res.ready);

    assign w_vx = pap_pkg::t_diff'(i_vtx.vertex_x)   - pap_pkg::t_diff'(r_prev_x);
    assign w_vy = pap_pkg::t_diff'(i_vtx.vertex_y)   - pap_pkg::t_diff'(r_prev_y);
    assign w_ex = pap_pkg::t_diff'(i_vtx.query_x)    - pap_pkg::t_diff'(r_prev_x);
    assign w_ey = pap_pkg::t_diff'(i_vtx.query_y)    - pap_pkg::t_diff'(r_prev_y);
    assign w_ds = pap_pkg::t_diff'(i_vtx.vertex_arc) - pap_pkg::t_diff'(r_prev_arc);

    assign w_len = w_mul_prod[0] + w_mul_prod[1];
    assign w_dot = pap_pkg::apply_sign(w_mul_prod[2], r_ex[MSB] ^ r_vx[MSB])
                 + pap_pkg::apply_sign(w_mul_prod[3], r_ey[MSB] ^ r_vy[MSB]);

    assign w_ratio_zero = r_dot[pap_pkg::DOT_W-1] | (r_dot == '0);
    assign w_ratio_one  = ~w_ratio_zero & ($unsigned(r_dot) >= pap_pkg::DOT_W'(r_len));
    assign w_div_start  = (r_state == S_RATIO) & ~w_ratio_zero & ~w_ratio_one;

    assign w_s_full = pap_pkg::t_diff'(r_arc0) + pap_pkg::signed_mag(r_ts, r_ds[MSB]);
    assign w_dsum   = {1'b0, w_mul_prod[0]} + {1'b0, w_mul_prod[1]};
    assign w_better = r_seg & (~r_have_best | (r_dist < r_best_dist));

    assign w_mul_start = ((r_state == S_SETUP) & r_seg) | (r_state == S_SCALE_GO)
                       | (r_state == S_SQ_GO);

    always_comb begin
        for (int k = 0; k < pap_pkg::N_MUL; k++) begin
            w_mul_a[k] = '0;
            w_mul_b[k] = '0;
        end
        unique case (r_state)
            S_SETUP: begin
                w_mul_a[0] = pap_pkg::mag_of(r_vx);
                w_mul_b[0] = pap_pkg::mag_of(r_vx);
                w_mul_a[1] = pap_pkg::mag_of(r_vy);
                w_mul_b[1] = pap_pkg::mag_of(r_vy);
                w_mul_a[2] = pap_pkg::mag_of(r_ex);
                w_mul_b[2] = pap_pkg::mag_of(r_vx);
                w_mul_a[3] = pap_pkg::mag_of(r_ey);
                w_mul_b[3] = pap_pkg::mag_of(r_vy);
            end
            S_SCALE_GO: begin
                w_mul_a[0] = pap_pkg::mag_of(r_vx);
                w_mul_b[0] = r_ratio;
                w_mul_a[1] = pap_pkg::mag_of(r_vy);
                w_mul_b[1] = r_ratio;
                w_mul_a[2] = pap_pkg::mag_of(r_ds);
                w_mul_b[2] = r_ratio;
            end
            S_SQ_GO: begin
                w_mul_a[0] = pap_pkg::mag_of(r_dx);
                w_mul_b[0] = pap_pkg::mag_of(r_dx);
                w_mul_a[1] = pap_pkg::mag_of(r_dy);
                w_mul_b[1] = pap_pkg::mag_of(r_dy);
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < pap_pkg::N_MUL; g++) begin : g_mul
        pap_serial_mul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_mul_start),
            .i_a     (w_mul_a[g]),
            .i_b     (w_mul_b[g]),
            .o_done  (w_mul_done[g]),
            .o_prod  (w_mul_prod[g])
        );
    end

    pap_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dot[pap_pkg::LEN_W-1:0]),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_vtx.valid) n_state = S_SETUP;
            S_SETUP:    n_state = r_seg ? S_PROD : S_FIN;
            S_PROD:     if (w_mul_done[0]) n_state = S_RATIO;
            S_RATIO:    n_state = (w_ratio_zero | w_ratio_one) ? S_SCALE_GO : S_DIV;
            S_DIV:      if (w_div_done) n_state = S_SCALE_GO;
            S_SCALE_GO: n_state = S_SCALE;
            S_SCALE:    if (w_mul_done[0]) n_state = S_DIFF;
            S_DIFF:     n_state = S_SQ_GO;
            S_SQ_GO:    n_state = S_SQ;
            S_SQ:       if (w_mul_done[0]) n_state = S_FIN;
            S_FIN:      n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT:     if (w_emit) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_arc  <= '0;
            r_best_dist <= pap_pkg::DIST_MAX;
            r_best_arc  <= '0;
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            priority if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_prev_x    <= i_vtx.vertex_x;
                r_prev_y    <= i_vtx.vertex_y;
                r_prev_arc  <= i_vtx.vertex_arc;
                r_have_prev <= 1'b1;
                if (i_vtx.first_vertex) begin
                    r_best_dist <= pap_pkg::DIST_MAX;
                    r_best_arc  <= '0;
                    r_have_best <= 1'b0;
                end
            end
            if ((r_state == S_FIN) && w_better) begin
                r_best_dist <= r_dist;
                r_best_arc  <= r_s;
                r_have_best <= 1'b1;
            end
            // hand the pass result over and drop tracking for the next pass
            if (w_emit) begin
                r_have_prev <= 1'b0;
                r_best_dist <= pap_pkg::DIST_MAX;
                r_best_arc  <= '0;
                r_have_best <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seg  <= r_have_prev & ~i_vtx.first_vertex & ((w_vx != '0) | (w_vy != '0));
            r_last <= i_vtx.last_vertex;
            r_vx   <= w_vx;
            r_vy   <= w_vy;
            r_ex   <= w_ex;
            r_ey   <= w_ey;
            r_ds   <= w_ds;
            r_arc0 <= r_prev_arc;
        end
        if ((r_state == S_PROD) && w_mul_done[0]) begin
            r_len <= w_len;
            r_dot <= w_dot;
        end
        if (r_state == S_RATIO) begin
            r_ratio <= w_ratio_one ? pap_pkg::RATIO_ONE : '0;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_ratio <= pap_pkg::MUL_W'(w_quot);
        end
        if ((r_state == S_SCALE) && w_mul_done[0]) begin
            r_tx <= pap_pkg::round_mag(w_mul_prod[0]);
            r_ty <= pap_pkg::round_mag(w_mul_prod[1]);
            r_ts <= pap_pkg::round_mag(w_mul_prod[2]);
        end
        if (r_state == S_DIFF) begin
            r_dx <= r_ex - pap_pkg::signed_mag(r_tx, r_vx[MSB]);
            r_dy <= r_ey - pap_pkg::signed_mag(r_ty, r_vy[MSB]);
            r_s  <= pap_pkg::t_coord'(w_s_full[pap_pkg::COORD_W-1:0]);
        end
        if ((r_state == S_SQ) && w_mul_done[0]) begin
            r_dist <= (w_dsum[pap_pkg::PROD_W:pap_pkg::DIST_W] != '0)
                    ? pap_pkg::DIST_MAX : w_dsum[pap_pkg::DIST_W-1:0];
        end
        if (w_emit) begin
            r_found   <= r_have_best;
            r_out_arc <= r_have_best ? r_best_arc : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.arc_position = r_out_arc;
endmodule

### src/pap_checker.sv
// ----------------------------------------------------------------------------
// Polyline arc projection port checker
// Port-level properties of the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "polyline_arc_projection_unit_macros.svh"

module pap_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_vtx_valid,
    input logic            i_vtx_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic            i_res_found,
    input pap_pkg::t_coord i_res_arc_position
);
    `PAP_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_found) && $stable(i_res_arc_position))
    `PAP_ASSERT_SAME(a_arc_zero_if_none, i_res_valid && !i_res_found, i_res_arc_position == '0)
    `PAP_ASSERT_NEXT(a_one_vertex_at_a_time, i_vtx_valid && i_vtx_ready, !i_vtx_ready)
    `PAP_ASSERT_SAME(a_result_from_busy, $rose(i_res_valid), $past(!i_vtx_ready))
endmodule

bind polyline_arc_projection_unit pap_checker u_pap_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_vtx_valid        (i_vtx.valid),
    .i_vtx_ready        (i_vtx.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_found        (o_res.found),
    .i_res_arc_position (o_res.arc_position)
);

### tb/sv/polyline_arc_projection_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline arc projection unit testbench
// Streams polyline passes into the unit, one vertex per transaction. A local
// fixed-point projection predicts the found flag and the arc position of
// each pass. Every result transaction is compared with the oldest
// prediction. Both channels idle at random, except in the closing stretch.
// ----------------------------------------------------------------------------
module polyline_arc_projection_unit_test;

    localparam int              ITEM_TARGET  = 400;
    localparam int              CALM_ITEMS   = 40;
    localparam int              CYCLE_LIMIT  = 400000;
    localparam int              DRAIN_CYCLES = 300;
    localparam logic [32:0]     RATIO_FULL   = 33'h1_0000_0000;
    localparam logic [63:0]     DIST_SAT     = '1;
    localparam pap_pkg::t_coord COORD_MIN    = 32'sh8000_0000;
    localparam pap_pkg::t_coord COORD_MAX    = 32'sh7fff_ffff;
    localparam pap_pkg::t_coord METRE        = 32'sh0001_0000;

    typedef struct {
        pap_pkg::t_coord qx;
        pap_pkg::t_coord qy;
        pap_pkg::t_coord x;
        pap_pkg::t_coord y;
        pap_pkg::t_coord arc;
        logic            is_first;
        logic            is_last;
    } t_vertex_item;

    typedef struct {
        logic            found;
        pap_pkg::t_coord arc;
    } t_arc_result;

    logic        i_clk;
    logic        i_rst_n;
    bit          calm;
    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;
    int unsigned items_sent  = 0;
    int          stall_left  = 0;

    t_arc_result expected_arcs[$];

    pap_pkg::t_coord anchor_x;
    pap_pkg::t_coord anchor_y;
    pap_pkg::t_coord anchor_arc;
    logic            has_anchor;
    logic [63:0]     nearest_dist;
    pap_pkg::t_coord nearest_arc;
    logic            has_nearest;

    pap_vtx_if vtx();
    pap_res_if res();

    polyline_arc_projection_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_res   (res.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void clear_nearest();
        nearest_dist = DIST_SAT;
        nearest_arc  = '0;
        has_nearest  = 1'b0;
    endfunction

    // round(span * ratio / 2^32), half away from zero
    function automatic logic signed [34:0] scaled_offset(input logic signed [34:0] span,
                                                         input logic [32:0] ratio);
        logic [34:0]        span_mag;
        logic [67:0]        prod;
        logic signed [34:0] off;
        span_mag = span[34] ? -span : span;
        prod     = {33'd0, span_mag} * {35'd0, ratio} + 68'h8000_0000;
        off      = $signed(prod[66:32]);
        return span[34] ? -off : off;
    endfunction

    function automatic void project_segment(input t_vertex_item v);
        logic signed [34:0] vx, vy, ex, ey, px, py, dx, dy, arc_span, arc_at;
        logic signed [69:0] len, dot;
        logic [103:0]       num;
        logic [32:0]        ratio;
        logic [71:0]        seg_dist;
        logic [63:0]        dist_sat;
        vx = v.x - anchor_x;
        vy = v.y - anchor_y;
        ex = v.qx - anchor_x;
        ey = v.qy - anchor_y;
        if (vx == 0 && vy == 0)
            return;
        len = vx * vx + vy * vy;
        dot = ex * vx + ey * vy;
        if (dot <= 0) begin
            ratio = '0;
        end else if (dot >= len) begin
            ratio = RATIO_FULL;
        end else begin
            num   = {34'd0, dot} << 32;
            ratio = 33'(num / {34'd0, len});
        end
        px       = anchor_x + scaled_offset(vx, ratio);
        py       = anchor_y + scaled_offset(vy, ratio);
        dx       = v.qx - px;
        dy       = v.qy - py;
        seg_dist = dx * dx + dy * dy;
        dist_sat = (seg_dist[71:64] != 0) ? DIST_SAT : seg_dist[63:0];
        if (!has_nearest || dist_sat < nearest_dist) begin
            arc_span     = v.arc - anchor_arc;
            arc_at       = anchor_arc + scaled_offset(arc_span, ratio);
            nearest_arc  = arc_at[31:0];
            nearest_dist = dist_sat;
            has_nearest  = 1'b1;
        end
    endfunction

    function automatic void project_vertex(input t_vertex_item v);
        t_arc_result r;
        if (v.is_first) begin
            clear_nearest();
            has_anchor = 1'b0;
        end
        if (has_anchor)
            project_segment(v);
        anchor_x   = v.x;
        anchor_y   = v.y;
        anchor_arc = v.arc;
        has_anchor = 1'b1;
        if (v.is_last) begin
            r.found = has_nearest;
            r.arc   = has_nearest ? nearest_arc : '0;
            expected_arcs.insert(expected_arcs.size(), r);
            clear_nearest();
            has_anchor = 1'b0;
        end
    endfunction

    function automatic t_vertex_item make_vertex(input pap_pkg::t_coord qx,
                                                 input pap_pkg::t_coord qy,
                                                 input pap_pkg::t_coord x,
                                                 input pap_pkg::t_coord y,
                                                 input pap_pkg::t_coord arc,
                                                 input logic is_first,
                                                 input logic is_last);
        t_vertex_item v;
        v.qx       = qx;
        v.qy       = qy;
        v.x        = x;
        v.y        = y;
        v.arc      = arc;
        v.is_first = is_first;
        v.is_last  = is_last;
        return v;
    endfunction

    function automatic pap_pkg::t_coord pick_coord(input int mode,
                                                   input pap_pkg::t_coord centre,
                                                   input int spread);
        case (mode)
            6, 7: return pap_pkg::t_coord'($urandom);
            9: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return -1;
                    default: return pap_pkg::t_coord'($urandom);
                endcase
            end
            default: return centre + int'($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    task automatic send_vertex(input t_vertex_item v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        vtx.valid        <= 1'b1;
        vtx.query_x      <= v.qx;
        vtx.query_y      <= v.qy;
        vtx.vertex_x     <= v.x;
        vtx.vertex_y     <= v.y;
        vtx.vertex_arc   <= v.arc;
        vtx.first_vertex <= v.is_first;
        vtx.last_vertex  <= v.is_last;
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        project_vertex(v);
        items_sent++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_arc_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_arcs.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b arc=%0d",
                                          res.found, res.arc_position));
            end else begin
                want = expected_arcs.pop_front();
                if (res.found !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b", res.found, want.found));
                if (res.arc_position !== want.arc)
                    report_mismatch($sformatf("arc_position %0d, want %0d",
                                              res.arc_position, want.arc));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    task automatic send_random_pass(input bit broken);
        int              n_vertices;
        int              mode;
        int              spread;
        pap_pkg::t_coord cx;
        pap_pkg::t_coord cy;
        t_vertex_item    v;
        n_vertices = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 7);
        mode       = $urandom_range(0, 9);
        spread     = 1 << $urandom_range(4, 22);
        cx         = $signed($urandom) >>> 1;
        cy         = $signed($urandom) >>> 1;
        v.qx       = pick_coord(mode, cx, spread);
        v.qy       = pick_coord(mode, cy, spread);
        v.x        = pick_coord(mode, cx, spread);
        v.y        = pick_coord(mode, cy, spread);
        v.arc      = $signed($urandom) >>> 2;
        for (int i = 0; i < n_vertices; i++) begin
            if (i > 0) begin
                // repeat the previous vertex now and then to form degenerate segments
                if (mode != 8 || $urandom_range(0, 1) == 0) begin
                    v.x = pick_coord(mode, cx, spread);
                    v.y = pick_coord(mode, cy, spread);
                end
                if (mode == 6 || mode == 7 || mode == 9)
                    v.arc = pap_pkg::t_coord'($urandom);
                else
                    v.arc = v.arc + pap_pkg::t_coord'($urandom_range(0, 2 * spread));
                if ($urandom_range(0, 7) == 0) begin
                    v.qx = pick_coord(mode, cx, spread);
                    v.qy = pick_coord(mode, cy, spread);
                end
            end
            v.is_first = broken ? ($urandom_range(0, 2) == 0) : (i == 0);
            v.is_last  = broken ? ($urandom_range(0, 3) == 0) : (i == n_vertices - 1);
            send_vertex(v);
        end
    endtask

    task automatic test_directed();
        // vertex with no predecessor after reset, then a tie on an out-and-back path
        send_vertex(make_vertex(0, 0, 0, 0, 0, 1'b0, 1'b0));
        send_vertex(make_vertex(5 * METRE, 3 * METRE, 10 * METRE, 0, 10 * METRE, 1'b0, 1'b0));
        send_vertex(make_vertex(5 * METRE, 3 * METRE, 0, 0, 20 * METRE, 1'b0, 1'b1));
        // single vertex pass
        send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                1'b1, 1'b1));
        // degenerate segments only
        send_vertex(make_vertex(0, 0, 7 * METRE, -7 * METRE, METRE, 1'b1, 1'b0));
        send_vertex(make_vertex(0, 0, 7 * METRE, -7 * METRE, 2 * METRE, 1'b0, 1'b0));
        send_vertex(make_vertex(0, 0, 7 * METRE, -7 * METRE, 3 * METRE, 1'b0, 1'b1));
        // projection clamped to the segment start
        send_vertex(make_vertex(4 * METRE, 2 * METRE, 0, 0, -3 * METRE, 1'b1, 1'b0));
        send_vertex(make_vertex(4 * METRE, 2 * METRE, -10 * METRE, 0, -13 * METRE,
                                1'b0, 1'b0));
        send_vertex(make_vertex(4 * METRE, 2 * METRE, -10 * METRE, -10 * METRE, -23 * METRE,
                                1'b0, 1'b1));
        // projection clamped to the segment end
        send_vertex(make_vertex(100 * METRE, -100 * METRE, 0, 0, 0, 1'b1, 1'b0));
        send_vertex(make_vertex(100 * METRE, -100 * METRE, 3, -7, -5, 1'b0, 1'b1));
        // inexact ratio on a negative segment, rounding away from zero
        send_vertex(make_vertex(-1, 5, 0, 0, 1, 1'b1, 1'b0));
        send_vertex(make_vertex(-1, 5, -3, 0, -2, 1'b0, 1'b1));
        // saturated distances, the earlier segment kept on the tie
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                                1'b1, 1'b0));
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MIN + 1, COORD_MIN, 0,
                                1'b0, 1'b0));
        send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                1'b0, 1'b1));
        // corner to corner with extreme arc lengths
        send_vertex(make_vertex(0, 0, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1, 1'b0));
        send_vertex(make_vertex(0, 0, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1));
        // query moving within a pass
        send_vertex(make_vertex(50 * METRE, 50 * METRE, 0, 0, 0, 1'b1, 1'b0));
        send_vertex(make_vertex(2 * METRE, METRE, 10 * METRE, 0, 10 * METRE, 1'b0, 1'b0));
        send_vertex(make_vertex(10 * METRE, 4 * METRE, 10 * METRE, 10 * METRE, 20 * METRE,
                                1'b0, 1'b1));
        // pass opened without a first mark after a last vertex
        send_vertex(make_vertex(METRE, 2 * METRE, METRE, METRE, 0, 1'b0, 1'b0));
        send_vertex(make_vertex(METRE, 2 * METRE, 2 * METRE, METRE, 100, 1'b0, 1'b1));
    endtask

    task automatic test_random_passes();
        while (items_sent < ITEM_TARGET - CALM_ITEMS)
            send_random_pass($urandom_range(0, 9) == 0);
    endtask

    task automatic test_unstalled_passes();
        calm = 1'b1;
        while (items_sent < ITEM_TARGET)
            send_random_pass(1'b0);
    endtask

    initial begin
        vtx.valid        <= 1'b0;
        vtx.query_x      <= '0;
        vtx.query_y      <= '0;
        vtx.vertex_x     <= '0;
        vtx.vertex_y     <= '0;
        vtx.vertex_arc   <= '0;
        vtx.first_vertex <= 1'b0;
        vtx.last_vertex  <= 1'b0;
        i_rst_n          <= 1'b0;
        calm       = 1'b0;
        anchor_x   = '0;
        anchor_y   = '0;
        anchor_arc = '0;
        has_anchor = 1'b0;
        clear_nearest();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_passes();
        test_unstalled_passes();

        vtx.valid <= 1'b0;
        while (expected_arcs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
